// ----- hw/rtl/segment_motion_interpolator_defines.svh -----
// Assertion macros used by the checker file.
`ifndef SEGMENT_MOTION_INTERPOLATOR_DEFINES_SVH
`define SEGMENT_MOTION_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication.
`define SMI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smi check failed");

// Next-cycle implication.
`define SMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smi check failed");

`endif

// ----- hw/rtl/smi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package smi_pkg;

	localparam int MOVERS_DEF     = 64;
	localparam int MOVE_SCALE_DEF = 1024;

	localparam logic [1:0] KIND_PLACE   = 2'd0;
	localparam logic [1:0] KIND_BEGIN   = 2'd1;
	localparam logic [1:0] KIND_ADVANCE = 2'd2;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_TPS    = 2'd2;

	localparam logic OP_DIV  = 1'b0;
	localparam logic OP_SQRT = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  mover_index;
		logic [11:0] target_x;
		logic [11:0] target_y;
		logic [31:0] tick;
		logic [15:0] speed;
	} cmd_t;

	typedef struct packed {
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic        moving;
		logic        arrived;
	} res_t;

	typedef struct packed {
		logic        act;
		logic [11:0] x;
		logic [11:0] y;
	} pos_ent_t;

	typedef struct packed {
		logic go;
		logic op;
	} iter_req_t;

	function automatic logic [11:0] clamp_axis(logic signed [13:0] v, logic [12:0] lim_raw);
		logic [12:0] lim;
		lim = (lim_raw == 13'd0) ? 13'd1 : ((lim_raw > 13'd4096) ? 13'd4096 : lim_raw);
		if (v < 0) return 12'd0;
		else if (v[12:0] >= lim) return 12'(lim - 13'd1);
		else return v[11:0];
	endfunction

	function automatic logic [11:0] abs13(logic signed [12:0] d);
		logic signed [12:0] n;
		n = -d;
		return d[12] ? n[11:0] : d[11:0];
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/smi_iter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared iterative unit: restoring divide (64 steps) or integer square root (32 steps).
module smi_iter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire smi_pkg::iter_req_t req,
	input  wire logic [63:0]       a,
	input  wire logic [31:0]       b,
	output logic                   done,
	output logic [63:0]            q
);

	logic        run_q;
	logic        op_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [63:0] n_q;
	logic [63:0] r_q;
	logic [63:0] x_q;
	logic [31:0] b_q;

	logic [63:0] lhs;
	logic [63:0] rhs;
	logic [64:0] diff;
	logic        ge;

	always_comb begin
		if (op_q == smi_pkg::OP_SQRT) begin
			lhs = n_q;
			rhs = r_q + x_q;
		end else begin
			lhs = {n_q[62:0], x_q[63]};
			rhs = {32'd0, b_q};
		end
		diff = {1'b0, lhs} - {1'b0, rhs};
		ge   = ~diff[64];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			op_q   <= smi_pkg::OP_DIV;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				op_q  <= req.op;
				cnt_q <= (req.op == smi_pkg::OP_SQRT) ? 6'd31 : 6'd63;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			n_q <= (req.op == smi_pkg::OP_SQRT) ? a : 64'd0;
			r_q <= 64'd0;
			x_q <= (req.op == smi_pkg::OP_SQRT) ? 64'h4000_0000_0000_0000 : a;
			b_q <= b;
		end else if (run_q) begin
			if (op_q == smi_pkg::OP_SQRT) begin
				n_q <= ge ? diff[63:0] : n_q;
				r_q <= ge ? ((r_q >> 1) + x_q) : (r_q >> 1);
				x_q <= x_q >> 2;
			end else begin
				n_q <= ge ? diff[63:0] : lhs;
				r_q <= {r_q[62:0], ge};
				x_q <= x_q << 1;
			end
		end
	end

	assign done = done_q;
	assign q    = r_q;

endmodule
`default_nettype wire

// ----- hw/rtl/segment_motion_interpolator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Flow: ST_MOD, ST_RD, ST_DEC; then place, cancel or idle items go to ST_FIN, a moving begin
// runs ST_BG0-4 and a square root, and an advance runs ST_A0-4 and a divide, then snaps or
// runs two offset divides. Busy drops with the done beat; the shared divide/sqrt unit (one
// bit per cycle) does the long steps. MOVERS below 64 makes ST_MOD subtract MOVERS repeatedly.
// Results are a one-cycle done strobe; the receiver cannot stall.
// Reset: config returns to defaults; a clearing pass (busy high) zeroes the movers' position entries.
module segment_motion_interpolator #(
	parameter int MOVERS     = smi_pkg::MOVERS_DEF,
	parameter int MOVE_SCALE = smi_pkg::MOVE_SCALE_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire smi_pkg::cmd_t cmd,
	output logic               busy,
	output logic               done,
	output smi_pkg::res_t      result,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [12:0]   cfg_data
);

	localparam int AW   = (MOVERS > 1) ? $clog2(MOVERS) : 1;
	localparam int LENW = 13 + $clog2(MOVE_SCALE);

	localparam logic [4:0] ST_CLR = 5'd0,  ST_IDLE = 5'd1, ST_MOD = 5'd2,  ST_RD  = 5'd3,
		ST_DEC = 5'd4,  ST_BG0 = 5'd5,  ST_BG1 = 5'd6,  ST_BG2 = 5'd7,  ST_BG3 = 5'd8,
		ST_BG4 = 5'd9,  ST_SQS = 5'd10, ST_SQW = 5'd11, ST_A0  = 5'd12, ST_A1  = 5'd13,
		ST_A2  = 5'd14, ST_A3  = 5'd15, ST_A4  = 5'd16, ST_DVS = 5'd17, ST_DVW = 5'd18,
		ST_OX0 = 5'd19, ST_OX1 = 5'd20, ST_OX2 = 5'd21, ST_OXW = 5'd22, ST_OY0 = 5'd23,
		ST_OY1 = 5'd24, ST_OY2 = 5'd25, ST_OYW = 5'd26, ST_FIN = 5'd27;

	typedef struct packed {
		logic [11:0]     sx;
		logic [11:0]     sy;
		logic [11:0]     ex;
		logic [11:0]     ey;
		logic [31:0]     st;
		logic [LENW-1:0] len;
	} seg_ent_t;

	logic [4:0]  state_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [9:0]  tps_q;
	logic [AW-1:0] clr_q;

	smi_pkg::cmd_t    cmd_q;
	logic [5:0]       idx_q;
	smi_pkg::pos_ent_t pos_mem [MOVERS];
	seg_ent_t         seg_mem [MOVERS];
	smi_pkg::pos_ent_t pos_rd_q;
	seg_ent_t         seg_rd_q;

	logic [11:0] ex_q, ey_q, nx_q, ny_q;
	logic        nact_q, arr_q;
	logic [31:0] t0_q, t1_q, trav_q;
	logic [63:0] acc_q, p_q, mul_q;
	logic signed [13:0] ox_q;
	smi_pkg::res_t out_q;
	logic          done_q;

	logic [31:0] mul_a, mul_b;
	logic [AW-1:0] addr;
	logic [AW-1:0] waddr;
	logic          pos_we;
	smi_pkg::pos_ent_t pos_wd;
	logic          seg_we;
	seg_ent_t      seg_wd;

	smi_pkg::iter_req_t it_req;
	logic [63:0] it_a;
	logic [31:0] it_b;
	logic        it_done;
	logic [63:0] it_q;

	logic [11:0] bdx, bdy, adx, ady;
	logic        adx_neg, ady_neg;
	logic [11:0] cex, cey;
	logic [31:0] elapsed;
	logic signed [13:0] offs;
	logic signed [13:0] sum_x, sum_y;

	smi_iter u_iter (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (it_req),
		.a     (it_a),
		.b     (it_b),
		.done  (it_done),
		.q     (it_q)
	);

	always_comb begin
		addr    = AW'(idx_q);
		cex     = smi_pkg::clamp_axis({2'b00, cmd_q.target_x}, width_q);
		cey     = smi_pkg::clamp_axis({2'b00, cmd_q.target_y}, height_q);
		bdx     = smi_pkg::abs13($signed({1'b0, ex_q}) - $signed({1'b0, pos_rd_q.x}));
		bdy     = smi_pkg::abs13($signed({1'b0, ey_q}) - $signed({1'b0, pos_rd_q.y}));
		adx     = smi_pkg::abs13($signed({1'b0, seg_rd_q.ex}) - $signed({1'b0, seg_rd_q.sx}));
		ady     = smi_pkg::abs13($signed({1'b0, seg_rd_q.ey}) - $signed({1'b0, seg_rd_q.sy}));
		adx_neg = seg_rd_q.ex < seg_rd_q.sx;
		ady_neg = seg_rd_q.ey < seg_rd_q.sy;
		elapsed = cmd_q.tick - seg_rd_q.st;
		offs    = (state_q == ST_OXW ? adx_neg : ady_neg) ? -$signed({2'b00, it_q[11:0]})
			: $signed({2'b00, it_q[11:0]});
		sum_x   = $signed({2'b00, seg_rd_q.sx}) + ox_q;
		sum_y   = $signed({2'b00, seg_rd_q.sy}) + offs;

		mul_a = 32'd0;
		mul_b = 32'd0;
		unique case (state_q)
			ST_BG0: begin mul_a = 32'(bdx); mul_b = 32'(MOVE_SCALE); end
			ST_BG1: begin mul_a = 32'(bdy); mul_b = 32'(MOVE_SCALE); end
			ST_BG2: begin mul_a = t0_q; mul_b = t0_q; end
			ST_BG3: begin mul_a = t1_q; mul_b = t1_q; end
			ST_A0:  begin mul_a = 32'(cmd_q.speed); mul_b = elapsed; end
			ST_A2:  begin mul_a = acc_q[31:0]; mul_b = 32'(MOVE_SCALE); end
			ST_A3:  begin mul_a = acc_q[63:32]; mul_b = 32'(MOVE_SCALE); end
			ST_OX0: begin mul_a = 32'(adx); mul_b = trav_q; end
			ST_OY0: begin mul_a = 32'(ady); mul_b = trav_q; end
			default: ;
		endcase

		it_req.go = (state_q == ST_SQS) || (state_q == ST_DVS) || (state_q == ST_OX2)
			|| (state_q == ST_OY2);
		it_req.op = (state_q == ST_SQS) ? smi_pkg::OP_SQRT : smi_pkg::OP_DIV;
		it_a      = acc_q;
		it_b      = (state_q == ST_DVS) ? 32'(tps_q) : 32'({seg_rd_q.len, 1'b0});

		pos_we = (state_q == ST_CLR) || (state_q == ST_FIN);
		waddr  = (state_q == ST_CLR) ? clr_q : addr;
		pos_wd = (state_q == ST_CLR) ? '0 : '{act: nact_q, x: nx_q, y: ny_q};
		seg_we = (state_q == ST_SQW) && it_done;
		seg_wd = '{sx: pos_rd_q.x, sy: pos_rd_q.y, ex: ex_q, ey: ey_q, st: cmd_q.tick,
			len: it_q[LENW-1:0]};
	end

	always_ff @(posedge clk) begin
		mul_q <= 64'(mul_a) * 64'(mul_b);
		if (pos_we) pos_mem[waddr] <= pos_wd;
		if (seg_we) seg_mem[addr] <= seg_wd;
		if (state_q == ST_RD) begin
			pos_rd_q <= pos_mem[addr];
			seg_rd_q <= seg_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd256;
			height_q <= 13'd256;
			tps_q    <= 10'd20;
		end else if (cfg_we) begin
			unique case (cfg_index)
				smi_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				smi_pkg::CFG_HEIGHT: height_q <= cfg_data;
				smi_pkg::CFG_TPS:    tps_q    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MOVERS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (start) state_q <= ST_MOD;
				ST_MOD:  if (32'(idx_q) < MOVERS) state_q <= ST_RD;
				ST_RD:   state_q <= ST_DEC;
				ST_DEC: begin
					priority if (cmd_q.kind == smi_pkg::KIND_BEGIN) begin
						if (!(cex == pos_rd_q.x && cey == pos_rd_q.y)) state_q <= ST_BG0;
						else state_q <= ST_FIN;
					end else if (cmd_q.kind == smi_pkg::KIND_ADVANCE && tps_q != 10'd0
						&& pos_rd_q.act && cmd_q.speed != 16'd0
						&& seg_rd_q.len != '0 && cmd_q.tick >= seg_rd_q.st) begin
						state_q <= ST_A0;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_BG0: state_q <= ST_BG1;
				ST_BG1: state_q <= ST_BG2;
				ST_BG2: state_q <= ST_BG3;
				ST_BG3: state_q <= ST_BG4;
				ST_BG4: state_q <= ST_SQS;
				ST_SQS: state_q <= ST_SQW;
				ST_SQW: if (it_done) state_q <= ST_FIN;
				ST_A0:  state_q <= ST_A1;
				ST_A1:  state_q <= ST_A2;
				ST_A2:  state_q <= ST_A3;
				ST_A3:  state_q <= ST_A4;
				ST_A4:  state_q <= ST_DVS;
				ST_DVS: state_q <= ST_DVW;
				ST_DVW: if (it_done) state_q <= (it_q >= 64'(seg_rd_q.len)) ? ST_FIN : ST_OX0;
				ST_OX0: state_q <= ST_OX1;
				ST_OX1: state_q <= ST_OX2;
				ST_OX2: state_q <= ST_OXW;
				ST_OXW: if (it_done) state_q <= ST_OY0;
				ST_OY0: state_q <= ST_OY1;
				ST_OY1: state_q <= ST_OY2;
				ST_OY2: state_q <= ST_OYW;
				ST_OYW: if (it_done) state_q <= ST_FIN;
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q <= cmd;
				idx_q <= cmd.mover_index;
			end
			ST_MOD: if (32'(idx_q) >= MOVERS) idx_q <= idx_q - 6'(MOVERS);
			ST_DEC: begin
				ex_q   <= cex;
				ey_q   <= cey;
				nx_q   <= pos_rd_q.x;
				ny_q   <= pos_rd_q.y;
				nact_q <= pos_rd_q.act;
				arr_q  <= 1'b0;
				if (cmd_q.kind == smi_pkg::KIND_PLACE) begin
					nx_q <= cex;
					ny_q <= cey;
				end else if (cmd_q.kind == smi_pkg::KIND_BEGIN) begin
					if (cex == pos_rd_q.x && cey == pos_rd_q.y) nact_q <= 1'b0;
				end else if (cmd_q.kind == smi_pkg::KIND_ADVANCE && tps_q != 10'd0
					&& pos_rd_q.act && (cmd_q.speed == 16'd0 || seg_rd_q.len == '0)) begin
					nact_q <= 1'b0;
				end
			end
			ST_BG1: t0_q <= mul_q[31:0];
			ST_BG2: t1_q <= mul_q[31:0];
			ST_BG3: acc_q <= mul_q;
			ST_BG4: acc_q <= acc_q + mul_q;
			ST_SQW: if (it_done) nact_q <= (it_q != 64'd0);
			ST_A1:  acc_q <= mul_q;
			ST_A3:  p_q <= mul_q;
			ST_A4:  acc_q <= p_q + {mul_q[31:0], 32'd0};
			ST_DVW: if (it_done) begin
				trav_q <= it_q[31:0];
				if (it_q >= 64'(seg_rd_q.len)) begin
					nx_q   <= seg_rd_q.ex;
					ny_q   <= seg_rd_q.ey;
					nact_q <= 1'b0;
					arr_q  <= 1'b1;
				end
			end
			ST_OX1, ST_OY1: acc_q <= {mul_q[62:0], 1'b0} + 64'(seg_rd_q.len);
			ST_OXW: if (it_done) ox_q <= offs;
			ST_OYW: if (it_done) begin
				nx_q <= smi_pkg::clamp_axis(sum_x, width_q);
				ny_q <= smi_pkg::clamp_axis(sum_y, height_q);
			end
			ST_FIN: out_q <= '{pos_x: nx_q, pos_y: ny_q, moving: nact_q, arrived: arr_q};
			default: ;
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = out_q;

endmodule
`default_nettype wire

// ----- hw/rtl/smi_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "segment_motion_interpolator_defines.svh"
module smi_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire smi_pkg::res_t result
);

	`SMI_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy)
	`SMI_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`SMI_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`SMI_ASSERT_NOW(a_arrive_stop, clk, arst_n, done && result.arrived, !result.moving)

endmodule

bind segment_motion_interpolator smi_checker u_smi_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
module tb;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [1:0] CFG_SPARE  = 2'd3;
	localparam int QUIET_LIMIT = 3000;

	logic          clk;
	logic          arst_n;
	logic          start;
	smi_pkg::cmd_t cmd;
	logic          busy;
	logic          done;
	smi_pkg::res_t result;
	logic          cfg_we;
	logic [1:0]    cfg_index;
	logic [12:0]   cfg_data;

	segment_motion_interpolator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy), .done(done),
		.result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// predictor state
	int unsigned       width_cfg, height_cfg, tps_cfg;
	logic [11:0]       px [64];
	logic [11:0]       py [64];
	logic              mv_on [64];
	logic [11:0]       sx0 [64];
	logic [11:0]       sy0 [64];
	logic [11:0]       sx1 [64];
	logic [11:0]       sy1 [64];
	logic [31:0]       s_tick [64];
	longint unsigned   s_len [64];
	logic [31:0]       tick_base [64];

	smi_pkg::res_t pending_pos [$];
	int    fails;
	int    quiet;
	int    idle_pct;

	function automatic logic [11:0] fit_axis(longint v, int unsigned lim_raw);
		longint lim;
		lim = lim_raw;
		if (lim < 1) lim = 1;
		if (lim > 4096) lim = 4096;
		if (v < 0) return 12'd0;
		if (v >= lim) return 12'(lim - 1);
		return 12'(v);
	endfunction

	function automatic longint unsigned floor_root(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint round_div(longint n, longint d);
		longint unsigned mag, q;
		mag = (n < 0) ? -n : n;
		q = (2 * mag + d) / (2 * d);
		return (n < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic smi_pkg::res_t next_position(smi_pkg::cmd_t c);
		int m;
		logic [11:0] ex, ey;
		longint dxs, dys, len, dx, dy;
		longint unsigned trav, el;
		smi_pkg::res_t r;
		m = c.mover_index;
		r.arrived = 1'b0;
		case (c.kind)
			smi_pkg::KIND_PLACE: begin
				px[m] = fit_axis(c.target_x, width_cfg);
				py[m] = fit_axis(c.target_y, height_cfg);
			end
			smi_pkg::KIND_BEGIN: begin
				ex = fit_axis(c.target_x, width_cfg);
				ey = fit_axis(c.target_y, height_cfg);
				if (ex == px[m] && ey == py[m]) begin
					mv_on[m] = 1'b0;
				end else begin
					dxs = (longint'(ex) - longint'(px[m])) * smi_pkg::MOVE_SCALE_DEF;
					dys = (longint'(ey) - longint'(py[m])) * smi_pkg::MOVE_SCALE_DEF;
					sx0[m] = px[m]; sy0[m] = py[m];
					sx1[m] = ex; sy1[m] = ey;
					s_tick[m] = c.tick;
					s_len[m] = floor_root(dxs * dxs + dys * dys);
					mv_on[m] = s_len[m] != 0;
				end
			end
			smi_pkg::KIND_ADVANCE: begin
				if (tps_cfg != 0 && mv_on[m]) begin
					if (c.speed == 0 || s_len[m] == 0) begin
						mv_on[m] = 1'b0;
					end else if (c.tick >= s_tick[m]) begin
						el = c.tick - s_tick[m];
						trav = (longint'(c.speed) * el * smi_pkg::MOVE_SCALE_DEF) / tps_cfg;
						if (trav >= s_len[m]) begin
							px[m] = sx1[m]; py[m] = sy1[m];
							mv_on[m] = 1'b0;
							r.arrived = 1'b1;
						end else begin
							len = s_len[m];
							dx = longint'(sx1[m]) - longint'(sx0[m]);
							dy = longint'(sy1[m]) - longint'(sy0[m]);
							px[m] = fit_axis(sx0[m] + round_div(dx * longint'(trav), len),
								width_cfg);
							py[m] = fit_axis(sy0[m] + round_div(dy * longint'(trav), len),
								height_cfg);
						end
					end
				end
			end
			default: ;
		endcase
		r.pos_x = px[m];
		r.pos_y = py[m];
		r.moving = mv_on[m];
		return r;
	endfunction

	task automatic send(smi_pkg::cmd_t c);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		pending_pos = {pending_pos, next_position(c)};
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_pos.size() != 0 || busy);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [12:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			smi_pkg::CFG_WIDTH:  width_cfg = val;
			smi_pkg::CFG_HEIGHT: height_cfg = val;
			smi_pkg::CFG_TPS:    tps_cfg = val[9:0];
			default: ;
		endcase
	endtask

	function automatic smi_pkg::cmd_t mk(logic [1:0] k, int m, int x, int y, logic [31:0] t,
		int s);
		smi_pkg::cmd_t c;
		c.kind = k; c.mover_index = 6'(m); c.target_x = 12'(x); c.target_y = 12'(y);
		c.tick = t; c.speed = 16'(s);
		return c;
	endfunction

	function automatic smi_pkg::cmd_t random_item();
		smi_pkg::cmd_t c;
		int m, p;
		m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
		p = $urandom_range(0, 99);
		c.mover_index = 6'(m);
		c.target_x = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
			: 12'($urandom_range(0, (width_cfg > 4096 ? 4096 : width_cfg) + 1));
		c.target_y = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
			: 12'($urandom_range(0, (height_cfg > 4096 ? 4096 : height_cfg) + 1));
		c.speed = 16'($urandom_range(1, 300));
		if ($urandom_range(0, 19) == 0) c.speed = 16'd0;
		else if ($urandom_range(0, 19) == 0) c.speed = 16'($urandom_range(0, 65535));
		if (p < 15) begin
			c.kind = smi_pkg::KIND_PLACE;
			c.tick = $urandom();
		end else if (p < 40) begin
			c.kind = smi_pkg::KIND_BEGIN;
			if ($urandom_range(0, 3) == 0) tick_base[m] = $urandom();
			c.tick = tick_base[m];
		end else if (p < 95) begin
			c.kind = smi_pkg::KIND_ADVANCE;
			if ($urandom_range(0, 14) == 0) c.tick = $urandom();
			else if ($urandom_range(0, 14) == 0) c.tick = tick_base[m] - $urandom_range(1, 5);
			else c.tick = tick_base[m] + $urandom_range(0, 60);
		end else begin
			c.kind = KIND_SPARE;
			c.tick = $urandom();
		end
		return c;
	endfunction

	always @(posedge clk) begin
		smi_pkg::res_t e;
		if (done) begin
			if (pending_pos.size() == 0) begin
				$error("result beat with nothing expected");
				fails++;
			end else begin
				e = pending_pos.pop_front();
				if (result.pos_x !== e.pos_x) begin
					$error("pos_x exp %0d got %0d", e.pos_x, result.pos_x); fails++;
				end
				if (result.pos_y !== e.pos_y) begin
					$error("pos_y exp %0d got %0d", e.pos_y, result.pos_y); fails++;
				end
				if (result.moving !== e.moving) begin
					$error("moving exp %0d got %0d", e.moving, result.moving); fails++;
				end
				if (result.arrived !== e.arrived) begin
					$error("arrived exp %0d got %0d", e.arrived, result.arrived); fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic test_directed();
		idle_pct = 0;
		send(mk(smi_pkg::KIND_PLACE, 0, 4095, 4095, 0, 0));
		send(mk(smi_pkg::KIND_PLACE, 0, 0, 0, 32'hFFFF_FFFF, 65535));
		send(mk(smi_pkg::KIND_BEGIN, 0, 0, 0, 5, 0));
		send(mk(smi_pkg::KIND_ADVANCE, 1, 10, 10, 10, 10));
		send(mk(smi_pkg::KIND_BEGIN, 0, 200, 100, 100, 0));
		send(mk(smi_pkg::KIND_ADVANCE, 0, 0, 0, 90, 50));
		send(mk(smi_pkg::KIND_ADVANCE, 0, 0, 0, 110, 50));
		send(mk(smi_pkg::KIND_PLACE, 0, 20, 20, 0, 0));
		send(mk(smi_pkg::KIND_ADVANCE, 0, 0, 0, 130, 50));
		send(mk(KIND_SPARE, 0, 4095, 4095, 32'hFFFF_FFFF, 65535));
		send(mk(smi_pkg::KIND_ADVANCE, 0, 0, 0, 200, 0));
		send(mk(smi_pkg::KIND_BEGIN, 63, 4095, 0, 32'hFFFF_FFF0, 0));
		send(mk(smi_pkg::KIND_ADVANCE, 63, 0, 0, 32'hFFFF_FFFF, 65535));
		send(mk(smi_pkg::KIND_PLACE, 63, 3, 7, 0, 0));
		send(mk(smi_pkg::KIND_BEGIN, 63, 0, 255, 1000, 0));
		send(mk(smi_pkg::KIND_ADVANCE, 63, 0, 0, 1003, 7));
		send(mk(smi_pkg::KIND_ADVANCE, 63, 0, 0, 1004, 1));
		send(mk(smi_pkg::KIND_ADVANCE, 63, 0, 0, 2000, 40));
	endtask

	task automatic test_config_extremes();
		idle_pct = 26;
		write_reg(smi_pkg::CFG_TPS, 13'd0);
		send(mk(smi_pkg::KIND_BEGIN, 5, 50, 50, 0, 0));
		send(mk(smi_pkg::KIND_ADVANCE, 5, 0, 0, 100, 100));
		write_reg(smi_pkg::CFG_WIDTH, 13'd0);
		write_reg(smi_pkg::CFG_HEIGHT, 13'h1FFF);
		write_reg(smi_pkg::CFG_TPS, 13'h1FFF);
		write_reg(CFG_SPARE, 13'h1555);
		send(mk(smi_pkg::KIND_PLACE, 6, 4095, 4095, 0, 0));
		send(mk(smi_pkg::KIND_BEGIN, 6, 0, 0, 0, 0));
		send(mk(smi_pkg::KIND_ADVANCE, 6, 0, 0, 500, 3));
		send(mk(smi_pkg::KIND_ADVANCE, 5, 0, 0, 1, 65535));
	endtask

	task automatic test_random(int n, int pct, int w, int h, int t);
		smi_pkg::cmd_t c;
		write_reg(smi_pkg::CFG_WIDTH, 13'(w));
		write_reg(smi_pkg::CFG_HEIGHT, 13'(h));
		write_reg(smi_pkg::CFG_TPS, 13'(t));
		idle_pct = pct;
		for (int i = 0; i < n; i++) begin
			c = random_item();
			send(c);
			if (i == n / 2) drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = smi_pkg::CFG_WIDTH;
		cfg_data = '0;
		fails = 0;
		quiet = 0;
		idle_pct = 0;
		width_cfg = 256; height_cfg = 256; tps_cfg = 20;
		for (int i = 0; i < 64; i++) begin
			px[i] = '0; py[i] = '0; mv_on[i] = 1'b0; tick_base[i] = $urandom_range(0, 1000);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random(260, 0, 256, 256, 20);
		test_random(200, 59, 4096, 4096, 1000);
		test_random(150, 26, 1, 1, 1);
		test_random(200, 59, 100, 37, 3);
		test_random(100, 0, 8191, 0, 0);
		test_random(120, 26, 640, 480, 60);
		drain();
		repeat (300) @(posedge clk);
		if (fails == 0 && pending_pos.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
